>>> sv/ste_pkg.sv
// Shared types and codes for the stabilizer tableau engine.
package ste_pkg;

    typedef enum logic [2:0] {
        FUNC_X      = 3'd0,
        FUNC_Z      = 3'd1,
        FUNC_H      = 3'd2,
        FUNC_S      = 3'd3,
        FUNC_CNOT   = 3'd4,
        FUNC_CZ     = 3'd5,
        FUNC_MEAS   = 3'd6,
        FUNC_REINIT = 3'd7
    } func_t;

    typedef struct packed {
        func_t       func;
        logic [5:0]  qubit_a;
        logic [5:0]  qubit_b;
        logic        random_bit;
    } cmd_t;

    typedef struct packed {
        logic        outcome;
        logic [5:0]  measured_qubit;
    } res_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_GRD,
        ST_GWR,
        ST_SRD,
        ST_SCHK,
        ST_MRD,
        ST_MWR,
        ST_PIV1,
        ST_PIV2,
        ST_DRD,
        ST_DCHK,
        ST_DMUL,
        ST_RES
    } state_t;

endpackage

>>> sv/ste_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/stabilizer_tableau_engine_unit.sv
// Top level of the stabilizer tableau engine: sequencer and row unit over a tableau RAM.
//
// Channels: cmd (valid/ready) takes one gate, measurement or reinit request;
// res (valid/ready) returns one outcome for each measurement; cfg (valid/ready)
// writes the qubit count, which takes effect at the next reinit.
// The tableau lives in one RAM of 2*MAX_QUBITS rows; one row is read and one
// written per pass of the row unit.
// A gate does one read and one write for each of the 2n rows.
// A measurement with a random outcome searches the stabilizers up to the
// pivot, then runs row multiplies over the 2n rows and rewrites the pivot;
// a determined outcome searches all n stabilizers, then reads each destabilizer
// and multiplies where needed. A gate on a qubit n or above is accepted and ignored.
// Reinit, and reset, sweep all 2*MAX_QUBITS rows at one row a cycle; cmd_ready
// is low meanwhile. After reset the tableau is the identity for the reset
// qubit count.
// The result waits in an output register; when it is still full and res_ready is
// low, a finished measurement holds in its last step until the register frees,
// and cmd_ready stays low until then. cfg_ready is always high.
module stabilizer_tableau_engine_unit #(
    parameter int MAX_QUBITS = 64
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  ste_pkg::cmd_t cmd,
    output logic          res_valid,
    input  logic          res_ready,
    output ste_pkg::res_t res,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [6:0]    cfg_data
);

    import ste_pkg::*;

    localparam int M    = MAX_QUBITS;
    localparam int ROWS = 2 * M;
    localparam int QW   = $clog2(M);
    localparam int RW   = $clog2(ROWS);
    localparam int CW   = RW + 1;
    localparam int NW   = $clog2(M + 1);
    localparam int DW   = 2 * M + 2;
    localparam int RESET_N = (64 > M) ? M : 64;

    function automatic logic [NW-1:0] sat_count(input logic [6:0] v);
        if (v == 7'd0)
            return NW'(1);
        else if (int'(v) > M)
            return NW'(M);
        else
            return NW'(v);
    endfunction

    function automatic logic [M-1:0] onehot(input logic [QW-1:0] i);
        return {{(M-1){1'b0}}, 1'b1} << i;
    endfunction

    function automatic logic [DW-1:0] row_h(input logic [DW-1:0] row,
                                            input logic [QW-1:0] q);
        logic [M-1:0] xv;
        logic [M-1:0] zv;
        logic [1:0]   pv;
        logic         xb;
        logic         zb;
        {pv, zv, xv} = row;
        xb = xv[q];
        zb = zv[q];
        if (xb && zb)
            pv = pv + 2'd2;
        xv[q] = zb;
        zv[q] = xb;
        return {pv, zv, xv};
    endfunction

    function automatic logic [DW-1:0] row_cnot(input logic [DW-1:0] row,
                                               input logic [QW-1:0] c,
                                               input logic [QW-1:0] t);
        logic [M-1:0] xv;
        logic [M-1:0] zv;
        logic [1:0]   pv;
        logic         xc;
        logic         zt;
        {pv, zv, xv} = row;
        xc = xv[c];
        zt = zv[t];
        xv[t] = xv[t] ^ xc;
        zv[c] = zv[c] ^ zt;
        return {pv, zv, xv};
    endfunction

    // target times source
    function automatic logic [DW-1:0] row_mul(input logic [DW-1:0] tgt,
                                              input logic [DW-1:0] src);
        logic [M-1:0] tx;
        logic [M-1:0] tz;
        logic [1:0]   tp;
        logic [M-1:0] sx;
        logic [M-1:0] sz;
        logic [1:0]   sp;
        logic         par;
        {tp, tz, tx} = tgt;
        {sp, sz, sx} = src;
        par = ^(tz & sx);
        return {tp + sp + {par, 1'b0}, tz ^ sz, tx ^ sx};
    endfunction

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [NW-1:0]   n_reg, n_next;
    logic [6:0]      cfg_reg, cfg_next;
    cmd_t            cmd_reg, cmd_next;
    logic [RW-1:0]   piv_reg, piv_next;
    logic [DW-1:0]   pivrow_reg, pivrow_next;
    logic [DW-1:0]   scr_reg, scr_next;
    res_t            res_reg, res_next;
    logic            res_valid_reg, res_valid_next;
    logic            out_bit_reg, out_bit_next;

    logic            ram_we;
    logic [RW-1:0]   ram_waddr;
    logic [DW-1:0]   ram_wdata;
    logic [RW-1:0]   ram_raddr;
    logic [DW-1:0]   ram_rdata;

    logic [CW-1:0]   n_c;
    logic [CW-1:0]   twon;
    logic [QW-1:0]   qa;
    logic [QW-1:0]   qb;
    logic            a_ok;
    logic            b_ok;
    logic [M-1:0]    rd_x;
    logic [CW-1:0]   diff;
    logic [M-1:0]    id_x;
    logic [M-1:0]    id_z;
    logic [DW-1:0]   gate_row;

    ste_ram #(
        .WIDTH(DW),
        .DEPTH(ROWS)
    ) u_tableau (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign n_c    = CW'(n_reg);
    assign twon   = CW'({n_reg, 1'b0});
    assign qa     = QW'(cmd_reg.qubit_a);
    assign qb     = QW'(cmd_reg.qubit_b);
    assign a_ok   = 32'(cmd.qubit_a) < 32'(n_reg);
    assign b_ok   = 32'(cmd.qubit_b) < 32'(n_reg);
    assign rd_x   = ram_rdata[M-1:0];
    assign diff   = cnt_reg - n_c;
    assign id_x   = (cnt_reg < n_c) ? onehot(cnt_reg[QW-1:0]) : '0;
    assign id_z   = (cnt_reg >= n_c && cnt_reg < twon) ? onehot(diff[QW-1:0]) : '0;

    always_comb
    begin
        logic [M-1:0] xv;
        logic [M-1:0] zv;
        logic [1:0]   pv;
        {pv, zv, xv} = ram_rdata;
        gate_row = ram_rdata;
        unique case (cmd_reg.func)
            FUNC_X:
            begin
                if (zv[qa])
                    gate_row = {pv + 2'd2, zv, xv};
            end
            FUNC_Z:
            begin
                if (xv[qa])
                    gate_row = {pv + 2'd2, zv, xv};
            end
            FUNC_H:
                gate_row = row_h(ram_rdata, qa);
            FUNC_S:
            begin
                if (xv[qa])
                begin
                    zv[qa] = ~zv[qa];
                    gate_row = {pv + 2'd1, zv, xv};
                end
            end
            FUNC_CNOT:
                gate_row = row_cnot(ram_rdata, qa, qb);
            FUNC_CZ:
                gate_row = row_h(row_cnot(row_h(ram_rdata, qb), qa, qb), qb);
            default:
                gate_row = ram_rdata;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        n_next         = n_reg;
        cfg_next       = cfg_reg;
        cmd_next       = cmd_reg;
        piv_next       = piv_reg;
        pivrow_next    = pivrow_reg;
        scr_next       = scr_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg;
        out_bit_next   = out_bit_reg;
        ram_we         = 1'b0;
        ram_waddr      = cnt_reg[RW-1:0];
        ram_wdata      = gate_row;
        ram_raddr      = cnt_reg[RW-1:0];
        cmd_ready      = 1'b0;

        if (cfg_valid)
            cfg_next = cfg_data;
        if (res_valid_reg && res_ready)
            res_valid_next = 1'b0;

        unique case (state_reg)
            ST_INIT:
            begin
                ram_we    = 1'b1;
                ram_wdata = {2'b00, id_z, id_x};
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg == CW'(ROWS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    cmd_next = cmd;
                    cnt_next = '0;
                    unique case (cmd.func)
                        FUNC_X, FUNC_Z, FUNC_H, FUNC_S:
                        begin
                            if (a_ok)
                                state_next = ST_GRD;
                        end
                        FUNC_CNOT, FUNC_CZ:
                        begin
                            if (a_ok && b_ok && cmd.qubit_a != cmd.qubit_b)
                                state_next = ST_GRD;
                        end
                        FUNC_MEAS:
                        begin
                            out_bit_next = 1'b0;
                            if (a_ok)
                            begin
                                cnt_next   = n_c;
                                state_next = ST_SRD;
                            end
                            else
                                state_next = ST_RES;
                        end
                        FUNC_REINIT:
                        begin
                            n_next     = sat_count(cfg_reg);
                            state_next = ST_INIT;
                        end
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_GRD:
                state_next = ST_GWR;
            ST_GWR:
            begin
                ram_we   = 1'b1;
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg + CW'(1) == twon)
                    state_next = ST_IDLE;
                else
                    state_next = ST_GRD;
            end
            ST_SRD:
                state_next = ST_SCHK;
            ST_SCHK:
            begin
                if (rd_x[qa])
                begin
                    piv_next    = cnt_reg[RW-1:0];
                    pivrow_next = ram_rdata;
                    cnt_next    = '0;
                    state_next  = ST_MRD;
                end
                else if (cnt_reg + CW'(1) == twon)
                begin
                    scr_next   = '0;
                    cnt_next   = '0;
                    state_next = ST_DRD;
                end
                else
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = ST_SRD;
                end
            end
            ST_MRD:
                state_next = ST_MWR;
            ST_MWR:
            begin
                ram_wdata = row_mul(ram_rdata, pivrow_reg);
                ram_we    = rd_x[qa] && (cnt_reg[RW-1:0] != piv_reg);
                cnt_next  = cnt_reg + CW'(1);
                if (cnt_reg + CW'(1) == twon)
                    state_next = ST_PIV1;
                else
                    state_next = ST_MRD;
            end
            ST_PIV1:
            begin
                ram_we     = 1'b1;
                ram_waddr  = RW'(CW'(piv_reg) - n_c);
                ram_wdata  = pivrow_reg;
                state_next = ST_PIV2;
            end
            ST_PIV2:
            begin
                ram_we       = 1'b1;
                ram_waddr    = piv_reg;
                ram_wdata    = {cmd_reg.random_bit, 1'b0, onehot(qa), {M{1'b0}}};
                out_bit_next = cmd_reg.random_bit;
                state_next   = ST_RES;
            end
            ST_DRD:
                state_next = ST_DCHK;
            ST_DCHK:
            begin
                if (rd_x[qa])
                begin
                    ram_raddr  = RW'(cnt_reg + n_c);
                    state_next = ST_DMUL;
                end
                else if (cnt_reg + CW'(1) == n_c)
                    state_next = ST_RES;
                else
                begin
                    cnt_next   = cnt_reg + CW'(1);
                    state_next = ST_DRD;
                end
            end
            ST_DMUL:
            begin
                scr_next     = row_mul(scr_reg, ram_rdata);
                out_bit_next = scr_next[DW-1];
                cnt_next     = cnt_reg + CW'(1);
                if (cnt_reg + CW'(1) == n_c)
                    state_next = ST_RES;
                else
                    state_next = ST_DRD;
            end
            ST_RES:
            begin
                if (!res_valid_reg || res_ready)
                begin
                    res_next.outcome        = out_bit_reg;
                    res_next.measured_qubit = cmd_reg.qubit_a;
                    res_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            cnt_reg       <= '0;
            n_reg         <= NW'(RESET_N);
            cfg_reg       <= 7'd64;
            res_valid_reg <= 1'b0;
            scr_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            n_reg         <= n_next;
            cfg_reg       <= cfg_next;
            res_valid_reg <= res_valid_next;
            scr_reg       <= scr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        piv_reg     <= piv_next;
        pivrow_reg  <= pivrow_next;
        res_reg     <= res_next;
        out_bit_reg <= out_bit_next;
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign cfg_ready = 1'b1;

endmodule

>>> sim/stabilizer_tableau_engine_unit_test.sv
// Testbench for the stabilizer tableau engine: directed and random requests against a tableau predictor.
`timescale 1ns / 1ps

module stabilizer_tableau_engine_unit_test;
    import ste_pkg::*;

    localparam int ROWS       = 128;
    localparam int SCRATCH    = 128;
    localparam int SETTLE     = 1200;
    localparam int STALL_LIMIT = 30000;

    logic       clk;
    logic       rst_n;
    logic       cmd_valid;
    logic       cmd_ready;
    cmd_t       cmd;
    logic       res_valid;
    logic       res_ready;
    res_t       res;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [6:0] cfg_data;

    logic [63:0] tab_x [0:ROWS];
    logic [63:0] tab_z [0:ROWS];
    logic [1:0]  tab_ph [0:ROWS];
    int          qubit_count;
    logic [6:0]  qubits_reg;

    res_t pending_outcomes[$];
    int   mismatches = 0;
    int   idle_cycles = 0;
    bit   no_gaps;

    stabilizer_tableau_engine_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    function automatic int clamp_count(logic [6:0] v);
        if (v == 7'd0)
        begin
            return 1;
        end
        if (v > 7'd64)
        begin
            return 64;
        end
        return int'(v);
    endfunction

    function automatic void build_identity();
        for (int r = 0; r <= ROWS; r++)
        begin
            tab_x[r]  = '0;
            tab_z[r]  = '0;
            tab_ph[r] = '0;
        end
        for (int q = 0; q < qubit_count; q++)
        begin
            tab_x[q][q] = 1'b1;
            tab_z[qubit_count + q][q] = 1'b1;
        end
    endfunction

    function automatic void mul_rows(int t, int s);
        logic [1:0] p;
        p = tab_ph[t] + tab_ph[s] + {^(tab_z[t] & tab_x[s]), 1'b0};
        tab_x[t]  ^= tab_x[s];
        tab_z[t]  ^= tab_z[s];
        tab_ph[t] = p;
    endfunction

    function automatic void apply_h(int q);
        for (int r = 0; r < 2 * qubit_count; r++)
        begin
            if (tab_x[r][q] && tab_z[r][q])
            begin
                tab_ph[r] += 2'd2;
            end
            if (tab_x[r][q] != tab_z[r][q])
            begin
                tab_x[r][q] = ~tab_x[r][q];
                tab_z[r][q] = ~tab_z[r][q];
            end
        end
    endfunction

    function automatic void apply_cnot(int c, int t);
        logic xc;
        logic zt;
        for (int r = 0; r < 2 * qubit_count; r++)
        begin
            xc = tab_x[r][c];
            zt = tab_z[r][t];
            if (xc)
            begin
                tab_x[r][t] = ~tab_x[r][t];
            end
            if (zt)
            begin
                tab_z[r][c] = ~tab_z[r][c];
            end
        end
    endfunction

    function automatic logic measure_qubit(int q, logic rnd);
        int n;
        int piv;
        n = qubit_count;
        piv = -1;
        for (int r = n; r < 2 * n; r++)
        begin
            if (piv < 0 && tab_x[r][q])
            begin
                piv = r;
            end
        end
        if (piv >= 0)
        begin
            for (int r = 0; r < 2 * n; r++)
            begin
                if (r != piv && tab_x[r][q])
                begin
                    mul_rows(r, piv);
                end
            end
            tab_x[piv - n]  = tab_x[piv];
            tab_z[piv - n]  = tab_z[piv];
            tab_ph[piv - n] = tab_ph[piv];
            tab_x[piv]      = '0;
            tab_z[piv]      = '0;
            tab_z[piv][q]   = 1'b1;
            tab_ph[piv]     = rnd ? 2'd2 : 2'd0;
            return rnd;
        end
        tab_x[SCRATCH]  = '0;
        tab_z[SCRATCH]  = '0;
        tab_ph[SCRATCH] = '0;
        for (int r = 0; r < n; r++)
        begin
            if (tab_x[r][q])
            begin
                mul_rows(SCRATCH, n + r);
            end
        end
        return tab_ph[SCRATCH][1];
    endfunction

    function automatic void tableau_apply(cmd_t c);
        int   a;
        int   b;
        bit   a_ok;
        bit   b_ok;
        res_t r;
        a = int'(c.qubit_a);
        b = int'(c.qubit_b);
        a_ok = a < qubit_count;
        b_ok = b < qubit_count;
        case (c.func)
            FUNC_X, FUNC_Z:
            begin
                if (a_ok)
                begin
                    for (int i = 0; i < 2 * qubit_count; i++)
                    begin
                        if ((c.func == FUNC_X) ? tab_z[i][a] : tab_x[i][a])
                        begin
                            tab_ph[i] += 2'd2;
                        end
                    end
                end
            end
            FUNC_H:
            begin
                if (a_ok)
                begin
                    apply_h(a);
                end
            end
            FUNC_S:
            begin
                if (a_ok)
                begin
                    for (int i = 0; i < 2 * qubit_count; i++)
                    begin
                        if (tab_x[i][a])
                        begin
                            tab_ph[i] += 2'd1;
                            tab_z[i][a] = ~tab_z[i][a];
                        end
                    end
                end
            end
            FUNC_CNOT:
            begin
                if (a_ok && b_ok && a != b)
                begin
                    apply_cnot(a, b);
                end
            end
            FUNC_CZ:
            begin
                if (a_ok && b_ok && a != b)
                begin
                    apply_h(b);
                    apply_cnot(a, b);
                    apply_h(b);
                end
            end
            FUNC_MEAS:
            begin
                r.outcome = a_ok ? measure_qubit(a, c.random_bit) : 1'b0;
                r.measured_qubit = c.qubit_a;
                pending_outcomes.insert(pending_outcomes.size(), r);
            end
            default:
            begin
                qubit_count = clamp_count(qubits_reg);
                build_identity();
            end
        endcase
    endfunction

    task automatic send_request(func_t f, int a, int b, bit rnd);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            cmd_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid = 1'b1;
        cmd.func = f;
        cmd.qubit_a = a[5:0];
        cmd.qubit_b = b[5:0];
        cmd.random_bit = rnd;
        do @(posedge clk); while (!cmd_ready);
        tableau_apply(cmd);
        @(negedge clk);
    endtask

    task automatic drain();
        cmd_valid = 1'b0;
        while (pending_outcomes.size() != 0) @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_qubits(logic [6:0] v);
        drain();
        cfg_valid = 1'b1;
        cfg_data  = v;
        do @(posedge clk); while (!cfg_ready);
        qubits_reg = v;
        @(negedge clk);
        cfg_valid = 1'b0;
        send_request(FUNC_REINIT, 0, 0, 0);
    endtask

    task automatic test_directed();
        send_request(FUNC_X, 0, 0, 0);
        send_request(FUNC_MEAS, 0, 63, 0);
        send_request(FUNC_Z, 63, 0, 1);
        send_request(FUNC_H, 63, 0, 0);
        send_request(FUNC_MEAS, 63, 0, 1);
        send_request(FUNC_MEAS, 63, 0, 0);
        send_request(FUNC_S, 5, 0, 0);
        send_request(FUNC_H, 7, 0, 0);
        send_request(FUNC_S, 7, 0, 0);
        send_request(FUNC_CNOT, 5, 5, 0);
        send_request(FUNC_CZ, 4, 4, 0);
        send_request(FUNC_CNOT, 7, 8, 0);
        send_request(FUNC_CZ, 7, 9, 1);
        send_request(FUNC_MEAS, 8, 0, 0);
        send_request(FUNC_MEAS, 9, 0, 1);
        send_request(FUNC_MEAS, 7, 0, 1);
        send_request(FUNC_REINIT, 63, 63, 1);
        send_request(FUNC_MEAS, 0, 0, 1);
        write_qubits(7'd4);
        send_request(FUNC_H, 10, 0, 0);
        send_request(FUNC_CNOT, 1, 40, 0);
        send_request(FUNC_MEAS, 63, 0, 1);
        send_request(FUNC_MEAS, 3, 0, 0);
    endtask

    task automatic random_phase(logic [6:0] v, int count);
        int   a;
        int   b;
        int   sel;
        func_t f;
        write_qubits(v);
        for (int i = 0; i < count; i++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 3)
            begin
                f = FUNC_REINIT;
            end
            else if (sel < 35)
            begin
                f = FUNC_MEAS;
            end
            else
            begin
                f = func_t'($urandom_range(0, 5));
            end
            if ($urandom_range(0, 9) == 0)
            begin
                a = $urandom_range(0, 63);
                b = $urandom_range(0, 63);
            end
            else
            begin
                a = $urandom_range(0, qubit_count - 1);
                b = $urandom_range(0, qubit_count - 1);
            end
            if ($urandom_range(0, 29) == 0)
            begin
                drain();
            end
            send_request(f, a, b, $urandom_range(0, 1));
        end
    endtask

    task automatic test_random();
        random_phase(7'd2, 60);
        random_phase(7'd0, 15);
        random_phase(7'd5, 70);
        no_gaps = 1'b1;
        random_phase(7'd3, 50);
        no_gaps = 1'b0;
        random_phase(7'd127, 40);
        random_phase(7'd8, 70);
        random_phase(7'd64, 40);
        random_phase(7'd42, 40);
        random_phase(7'd1, 20);
    endtask

    initial
    begin
        int stall;
        forever
        begin
            @(negedge clk);
            stall = no_gaps ? 0 : $urandom_range(0, 8);
            res_ready = 1'b0;
            repeat (stall) @(negedge clk);
            res_ready = 1'b1;
            do @(posedge clk); while (!res_valid);
            if (pending_outcomes.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result: outcome %0d qubit %0d",
                             res.outcome, res.measured_qubit);
                end
            end
            else if (res !== pending_outcomes[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("mismatch: expected outcome %0d qubit %0d, got outcome %0d qubit %0d",
                             pending_outcomes[0].outcome, pending_outcomes[0].measured_qubit,
                             res.outcome, res.measured_qubit);
                end
                void'(pending_outcomes.pop_front());
            end
            else
            begin
                void'(pending_outcomes.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        cmd_valid   = 1'b0;
        cmd         = '0;
        res_ready   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        no_gaps     = 1'b0;
        qubits_reg  = 7'd64;
        qubit_count = clamp_count(qubits_reg);
        build_identity();
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_random();
        drain();
        if (mismatches == 0 && pending_outcomes.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/ste_pkg.sv
sv/ste_ram.sv
sv/stabilizer_tableau_engine_unit.sv
sim/stabilizer_tableau_engine_unit_test.sv
